// ===== sv/grayscale_contrast_stretch_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the contrast stretch unit
// Implication and next-cycle checks, clocked on i_clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef GRAYSCALE_CONTRAST_STRETCH_UNIT_ASSERT_SVH
`define GRAYSCALE_CONTRAST_STRETCH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define GCSU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GCSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GCSU_ASSERT_IMP(lbl, ante, cons)
`define GCSU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/gcs_pkg.sv =====
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared constants and types of the contrast stretch unit.
// ----------------------------------------------------------------------------
package gcs_pkg;

    localparam int PIXEL_BITS_DEF = 16;
    // Output is 8 bits; 255 = 2**QUOT_BITS - 1.
    localparam int QUOT_BITS      = 8;
    localparam logic [QUOT_BITS-1:0] OUT_MAX = {QUOT_BITS{1'b1}};

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ===== sv/grayscale_contrast_stretch_unit.sv =====
// ----------------------------------------------------------------------------
// grayscale_contrast_stretch_unit
// Min-max contrast stretch of grayscale samples to 8 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) takes one item per handshake: mode 0
//   folds the pixel into the running min/max (first restarts them), mode 1
//   scales the pixel to round((v-min)*255/(max-min)).
//   Gather items give no result and do not stall the input. Scale items give one
//   result on the output channel (o_valid / i_stall).
//   A scale item passes through operand setup, divider load, 8 quotient-bit
//   steps of the serial divider, result capture and output load. Out-of-range
//   and flat cases skip the divider.
//   The input stalls while a scale item is in flight. A finished result sits
//   in the output register, so the next item is accepted while it waits.
//   If the receiver stalls and a new result is ready, the block holds it and
//   keeps the input stalled until the output register frees up.
//   Reset (synchronous, active low) empties the min/max range; scaling
//   before any gather reports flat.
// ----------------------------------------------------------------------------
`include "grayscale_contrast_stretch_unit_assert.svh"

module grayscale_contrast_stretch_unit #(
    parameter int PIXEL_BITS = gcs_pkg::PIXEL_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_mode,
    input  logic       i_first,
    input  logic [15:0] i_pixel_in,
    // output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_pixel_out,
    output logic       o_flat
);

    localparam int QB = gcs_pkg::QUOT_BITS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CALC = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic                  acc;
    logic                  out_free;
    logic [PIXEL_BITS-1:0] pix;

    logic [PIXEL_BITS-1:0] low;
    logic [PIXEL_BITS-1:0] high;

    // scale item operands and pending result
    logic [PIXEL_BITS-1:0] r_v;
    logic [PIXEL_BITS-1:0] r_d;
    logic [PIXEL_BITS-1:0] n_d;
    logic [PIXEL_BITS-1:0] r_den;
    logic [PIXEL_BITS-1:0] n_den;
    logic [QB-1:0]         r_res;
    logic [QB-1:0]         n_res;
    logic                  r_rflat;
    logic                  n_rflat;
    logic                  r_start;
    logic                  n_start;

    // output register
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [QB-1:0]         r_out_pix;
    logic [QB-1:0]         n_out_pix;
    logic                  r_out_flat;
    logic                  n_out_flat;

    gcs_pkg::t_div_sts     div_sts;
    logic [QB-1:0]         div_quot;

    assign pix      = i_pixel_in[PIXEL_BITS-1:0];
    assign o_stall  = (r_state != S_IDLE);
    assign acc      = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    gcs_stats #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (acc && !i_mode),
        .i_first (i_first),
        .i_pix   (pix),
        .o_low   (low),
        .o_high  (high)
    );

    gcs_div #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_d     (r_d),
        .i_den   (r_den),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_d         = r_d;
        n_den       = r_den;
        n_res       = r_res;
        n_rflat     = r_rflat;
        n_start     = 1'b0;
        n_out_valid = r_out_valid && i_stall;
        n_out_pix   = r_out_pix;
        n_out_flat  = r_out_flat;
        case (r_state)
            S_IDLE: begin
                if (acc && i_mode) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                // stats cannot move while a scale item is in flight
                if (high <= low) begin
                    // flat image, or no statistics gathered yet
                    n_res   = '0;
                    n_rflat = 1'b1;
                    n_state = S_DONE;
                end else if (r_v <= low) begin
                    n_res   = '0;
                    n_rflat = 1'b0;
                    n_state = S_DONE;
                end else if (r_v >= high) begin
                    n_res   = gcs_pkg::OUT_MAX;
                    n_rflat = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_d     = r_v - low;
                    n_den   = high - low;
                    n_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_sts.done && !r_start) begin
                    n_res   = div_quot;
                    n_rflat = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = r_res;
                    n_out_flat  = r_rflat;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_v <= pix;
        end
        r_d        <= n_d;
        r_den      <= n_den;
        r_res      <= n_res;
        r_rflat    <= n_rflat;
        r_out_pix  <= n_out_pix;
        r_out_flat <= n_out_flat;
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_out_pix;
    assign o_flat      = r_out_flat;

    // a flat result always reads as zero
    `GCSU_ASSERT_IMP(a_flat_zero, r_out_valid && r_out_flat, r_out_pix == '0)
    // a restarting gather leaves an empty-width range
    `GCSU_ASSERT_NEXT(a_first_restart, acc && !i_mode && i_first, low == high)
    // the divider only runs for the item in the divide state
    `GCSU_ASSERT_IMP(a_div_owned, div_sts.busy, r_state == S_DIV)
    // a start pulse always launches the divider
    `GCSU_ASSERT_NEXT(a_div_launch, r_start, div_sts.busy && !div_sts.done)

endmodule

// ===== sv/gcs_stats.sv =====
// ----------------------------------------------------------------------------
// gcs_stats
// Running minimum and maximum of the gathered pixels.
// ----------------------------------------------------------------------------
module gcs_stats #(
    parameter int PIXEL_BITS = gcs_pkg::PIXEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_upd,
    input  logic                  i_first,
    input  logic [PIXEL_BITS-1:0] i_pix,
    output logic [PIXEL_BITS-1:0] o_low,
    output logic [PIXEL_BITS-1:0] o_high
);

    logic [PIXEL_BITS-1:0] r_low;
    logic [PIXEL_BITS-1:0] r_high;
    logic [PIXEL_BITS-1:0] n_low;
    logic [PIXEL_BITS-1:0] n_high;

    always_comb begin
        n_low  = r_low;
        n_high = r_high;
        if (i_upd) begin
            if (i_first) begin
                n_low  = i_pix;
                n_high = i_pix;
            end else begin
                if (i_pix < r_low) begin
                    n_low = i_pix;
                end
                if (i_pix > r_high) begin
                    n_high = i_pix;
                end
            end
        end
    end

    // empty range after reset: low all ones, high zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= {PIXEL_BITS{1'b1}};
            r_high <= '0;
        end else begin
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

    assign o_low  = r_low;
    assign o_high = r_high;

endmodule

// ===== sv/gcs_div.sv =====
// ----------------------------------------------------------------------------
// gcs_div
// Bit-serial restoring divider: round(d * 255 / den), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module gcs_div #(
    parameter int PIXEL_BITS = gcs_pkg::PIXEL_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [PIXEL_BITS-1:0]           i_d,
    input  logic [PIXEL_BITS-1:0]           i_den,
    output gcs_pkg::t_div_sts               o_sts,
    output logic [gcs_pkg::QUOT_BITS-1:0]   o_quot
);

    localparam int QB = gcs_pkg::QUOT_BITS;
    localparam int W  = PIXEL_BITS;
    localparam int NW = W + QB + 1;
    localparam int CW = $clog2(QB);

    // numerator 2*255*d + den over divisor 2*den gives the rounded quotient
    logic [NW-1:0] num_full;
    logic [W+1:0]  trial;
    logic [W+1:0]  diff;
    logic          ge;

    logic [W:0]    r_rem;
    logic [QB-1:0] r_nlo;
    logic [W:0]    r_div;
    logic [QB-1:0] r_quot;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    assign num_full = {i_d, {(QB + 1){1'b0}}}
                    - {{QB{1'b0}}, i_d, 1'b0}
                    + {{(QB + 1){1'b0}}, i_den};

    assign trial = {r_rem, r_nlo[QB-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    // payload shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= num_full[NW-1:QB];
            r_nlo <= num_full[QB-1:0];
            r_div <= {i_den, 1'b0};
        end else if (r_busy) begin
            r_rem  <= ge ? diff[W:0] : trial[W:0];
            r_nlo  <= {r_nlo[QB-2:0], 1'b0};
            r_quot <= {r_quot[QB-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CW'(QB - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quot;

endmodule
